FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, switched off while the active-low reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`endif

FILE: rtl/core/tsdc_pkg.sv
package tsdc_pkg;

    localparam int MAX_CITIES = 64;
    localparam int CITY_W     = 6;
    localparam int CC_W       = 7;
    localparam int DIST_W     = 16;
    localparam int DADDR_W    = 12;
    localparam int COST_W     = 23;
    localparam int OCOST_W    = 22;
    localparam int DELTA_W    = 20;
    localparam int ACC_W      = 24;
    localparam int SUM_W      = 25;
    localparam int STEP_W     = 6;

    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;

    // Read slots used while gathering the neighbourhood of both swap positions.
    localparam int TOUR_SLOTS = 6;
    localparam int SLOT_CUR_A = 1;
    // Distance terms of a swap: the first ones are removed edges, the last two
    // are the shared edge pair that only counts for adjacent positions.
    localparam int DIST_SLOTS = 10;
    localparam int NEG_SLOTS  = 4;
    localparam int GATE_SLOT  = 8;

    localparam logic [CC_W-1:0] CC_RESET = CC_W'(MAX_CITIES);
    localparam logic [CC_W-1:0] CC_MIN   = CC_W'(2);

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_INIT  = 2'd1,
        FUNC_SWAP  = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    typedef struct packed {
        logic              load;
        logic              dist_wr;
        logic              dist_rd;
        logic              tour_rd;
        logic              tour_wr;
        logic              tour_wr_b;
        logic              tour_clear;
        logic              finish;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        t_func             func;
        logic              swap_ok;
        logic [CITY_W-1:0] n_m1;
    } t_status;

endpackage

FILE: rtl/core/tsdc_ram.sv
module tsdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_q <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: rtl/core/tsdc_ctrl.sv
module tsdc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  tsdc_pkg::t_status i_status,
    output tsdc_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WRITE,
        S_INIT,
        S_INIT_WAIT,
        S_TOUR_RD,
        S_DIST_RD,
        S_WR_A,
        S_WR_B,
        S_READ,
        S_READ_WAIT,
        S_FINISH
    } t_state;

    t_state                          r_state;
    logic [tsdc_pkg::STEP_W-1:0]     r_step;
    logic                            r_out_valid;
    logic                            w_load;
    logic                            w_finish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_load      = i_in_valid && (r_state == S_IDLE);
    // The result register may be refilled once its content is gone or leaves now.
    assign w_finish    = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = w_load;
        o_cmd.finish     = w_finish;
        o_cmd.step       = (r_state == S_READ) ?
                           tsdc_pkg::STEP_W'(tsdc_pkg::SLOT_CUR_A) : r_step;
        o_cmd.dist_wr    = (r_state == S_WRITE);
        o_cmd.dist_rd    = (r_state == S_INIT) || (r_state == S_DIST_RD);
        o_cmd.tour_rd    = (r_state == S_TOUR_RD) || (r_state == S_READ);
        o_cmd.tour_wr    = (r_state == S_WR_A) || (r_state == S_WR_B);
        o_cmd.tour_wr_b  = (r_state == S_WR_B);
        o_cmd.tour_clear = (r_state == S_DISPATCH) &&
                           (i_status.func == tsdc_pkg::FUNC_INIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (w_load) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    unique case (i_status.func)
                        tsdc_pkg::FUNC_WRITE: r_state <= S_WRITE;
                        tsdc_pkg::FUNC_INIT:  r_state <= S_INIT;
                        tsdc_pkg::FUNC_SWAP: begin
                            r_state <= i_status.swap_ok ? S_TOUR_RD : S_FINISH;
                        end
                        tsdc_pkg::FUNC_READ:  r_state <= S_READ;
                        default:              r_state <= S_FINISH;
                    endcase
                end
                S_WRITE: r_state <= S_FINISH;
                S_INIT: begin
                    if (r_step == i_status.n_m1) begin
                        r_step  <= '0;
                        r_state <= S_INIT_WAIT;
                    end else begin
                        r_step <= tsdc_pkg::STEP_W'(r_step + 1'b1);
                    end
                end
                S_INIT_WAIT: r_state <= S_FINISH;
                S_TOUR_RD: begin
                    if (r_step == tsdc_pkg::STEP_W'(tsdc_pkg::TOUR_SLOTS - 1)) begin
                        r_step  <= '0;
                        r_state <= S_DIST_RD;
                    end else begin
                        r_step <= tsdc_pkg::STEP_W'(r_step + 1'b1);
                    end
                end
                S_DIST_RD: begin
                    if (r_step == tsdc_pkg::STEP_W'(tsdc_pkg::DIST_SLOTS - 1)) begin
                        r_step  <= '0;
                        r_state <= S_WR_A;
                    end else begin
                        r_step <= tsdc_pkg::STEP_W'(r_step + 1'b1);
                    end
                end
                S_WR_A:      r_state <= S_WR_B;
                S_WR_B:      r_state <= S_FINISH;
                S_READ:      r_state <= S_READ_WAIT;
                S_READ_WAIT: r_state <= S_FINISH;
                S_FINISH: begin
                    if (w_finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/tsdc_dp.sv
module tsdc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tsdc_pkg::CC_W-1:0]           i_cfg_wdata,
    input  logic [tsdc_pkg::IN_TDATA_W-1:0]     i_tdata,
    input  logic [tsdc_pkg::IN_TUSER_W-1:0]     i_tuser,
    input  tsdc_pkg::t_cmd                      i_cmd,
    output tsdc_pkg::t_status                   o_status,
    output logic [tsdc_pkg::OUT_TDATA_W-1:0]    o_tdata
);

    localparam logic signed [tsdc_pkg::ACC_W-1:0] DMAX =
        tsdc_pkg::ACC_W'(2 ** (tsdc_pkg::DELTA_W - 1) - 1);
    localparam logic signed [tsdc_pkg::ACC_W-1:0] DMIN =
        -tsdc_pkg::ACC_W'(2 ** (tsdc_pkg::DELTA_W - 1));
    localparam logic signed [tsdc_pkg::SUM_W-1:0] CMAX =
        tsdc_pkg::SUM_W'(2 ** tsdc_pkg::COST_W - 1);

    // Configuration and the item in work.
    logic [tsdc_pkg::CC_W-1:0]           r_city_count;
    tsdc_pkg::t_func                     r_func;
    logic [tsdc_pkg::CITY_W-1:0]         r_row, r_col, r_pa, r_pb;
    logic [tsdc_pkg::DIST_W-1:0]         r_dist;

    // Running cost and the accumulator of the current operation.
    logic [tsdc_pkg::COST_W-1:0]         r_cost;
    logic signed [tsdc_pkg::ACC_W-1:0]   r_acc;

    // Tour store: a RAM with one valid bit per position, invalid means identity.
    logic [tsdc_pkg::MAX_CITIES-1:0]     r_tvalid;
    logic                                r_tv_hit;
    logic [tsdc_pkg::CITY_W-1:0]         r_taddr_q;
    logic                                r_tcap_en;
    logic [2:0]                          r_tcap_slot;
    logic [tsdc_pkg::CITY_W-1:0]         r_nb [tsdc_pkg::TOUR_SLOTS];

    logic                                r_acc_en, r_acc_neg, r_acc_gate;
    logic [tsdc_pkg::OUT_TDATA_W-1:0]    r_out;

    logic [tsdc_pkg::CC_W-1:0]           w_n;
    logic [tsdc_pkg::CITY_W-1:0]         w_n_m1;
    logic                                w_pa_ok, w_pb_ok, w_swap_ok, w_adj;
    logic [tsdc_pkg::CITY_W-1:0]         w_prev_a, w_next_a, w_prev_b, w_next_b;
    logic [tsdc_pkg::CITY_W-1:0]         w_trd_addr, w_t_addr, w_t_wdata, w_t_q, w_t_rdata;
    logic                                w_t_en;
    logic [tsdc_pkg::CITY_W-1:0]         w_d_row, w_d_col;
    logic [tsdc_pkg::DADDR_W-1:0]        w_d_addr;
    logic                                w_d_en;
    logic [tsdc_pkg::DIST_W-1:0]         w_d_q;
    logic signed [tsdc_pkg::ACC_W-1:0]   w_d_ext;
    logic signed [tsdc_pkg::SUM_W-1:0]   w_sum;
    logic [tsdc_pkg::COST_W-1:0]         w_new_cost;
    logic [tsdc_pkg::OCOST_W-1:0]        w_out_cost;
    logic [tsdc_pkg::DELTA_W-1:0]        w_delta;
    logic [tsdc_pkg::CITY_W-1:0]         w_city;
    logic                                w_is_swap;

    // Active city count, saturated into the legal range.
    always_comb begin
        if (r_city_count < tsdc_pkg::CC_MIN) begin
            w_n = tsdc_pkg::CC_MIN;
        end else if (r_city_count > tsdc_pkg::CC_RESET) begin
            w_n = tsdc_pkg::CC_RESET;
        end else begin
            w_n = r_city_count;
        end
    end

    assign w_n_m1    = tsdc_pkg::CITY_W'(w_n - 1'b1);
    assign w_pa_ok   = {1'b0, r_pa} < w_n;
    assign w_pb_ok   = {1'b0, r_pb} < w_n;
    assign w_swap_ok = w_pa_ok && w_pb_ok && (r_pa != r_pb);
    assign w_is_swap = (r_func == tsdc_pkg::FUNC_SWAP);

    assign o_status.func    = r_func;
    assign o_status.swap_ok = w_swap_ok;
    assign o_status.n_m1    = w_n_m1;

    // Wraparound neighbours of both positions.
    assign w_prev_a = (r_pa == '0) ? w_n_m1 : tsdc_pkg::CITY_W'(r_pa - 1'b1);
    assign w_next_a = (r_pa == w_n_m1) ? '0 : tsdc_pkg::CITY_W'(r_pa + 1'b1);
    assign w_prev_b = (r_pb == '0) ? w_n_m1 : tsdc_pkg::CITY_W'(r_pb - 1'b1);
    assign w_next_b = (r_pb == w_n_m1) ? '0 : tsdc_pkg::CITY_W'(r_pb + 1'b1);

    always_comb begin
        unique case (i_cmd.step[2:0])
            3'd0:    w_trd_addr = w_prev_a;
            3'd1:    w_trd_addr = r_pa;
            3'd2:    w_trd_addr = w_next_a;
            3'd3:    w_trd_addr = w_prev_b;
            3'd4:    w_trd_addr = r_pb;
            default: w_trd_addr = w_next_b;
        endcase
    end

    assign w_t_en    = i_cmd.tour_rd || i_cmd.tour_wr;
    assign w_t_addr  = i_cmd.tour_wr ? (i_cmd.tour_wr_b ? r_pb : r_pa) : w_trd_addr;
    // Position a takes the city from b, and b the one from a.
    assign w_t_wdata = i_cmd.tour_wr_b ? r_nb[1] : r_nb[4];
    assign w_t_rdata = r_tv_hit ? w_t_q : r_taddr_q;

    tsdc_ram #(
        .WIDTH (tsdc_pkg::CITY_W),
        .DEPTH (tsdc_pkg::MAX_CITIES)
    ) u_tour_ram (
        .i_clk   (i_clk),
        .i_en    (w_t_en),
        .i_we    (i_cmd.tour_wr),
        .i_addr  (w_t_addr),
        .i_wdata (w_t_wdata),
        .o_rdata (w_t_q)
    );

    // Distance address: the closed identity tour for init, the swap terms otherwise.
    always_comb begin
        if (r_func == tsdc_pkg::FUNC_INIT) begin
            w_d_row = i_cmd.step;
            w_d_col = (i_cmd.step == w_n_m1) ? '0 : tsdc_pkg::CITY_W'(i_cmd.step + 1'b1);
        end else begin
            unique case (i_cmd.step[3:0])
                4'd0:    begin w_d_row = r_nb[0]; w_d_col = r_nb[1]; end
                4'd1:    begin w_d_row = r_nb[1]; w_d_col = r_nb[2]; end
                4'd2:    begin w_d_row = r_nb[3]; w_d_col = r_nb[4]; end
                4'd3:    begin w_d_row = r_nb[4]; w_d_col = r_nb[5]; end
                4'd4:    begin w_d_row = r_nb[3]; w_d_col = r_nb[1]; end
                4'd5:    begin w_d_row = r_nb[1]; w_d_col = r_nb[5]; end
                4'd6:    begin w_d_row = r_nb[0]; w_d_col = r_nb[4]; end
                4'd7:    begin w_d_row = r_nb[4]; w_d_col = r_nb[2]; end
                4'd8:    begin w_d_row = r_nb[1]; w_d_col = r_nb[4]; end
                default: begin w_d_row = r_nb[4]; w_d_col = r_nb[1]; end
            endcase
        end
    end

    assign w_d_en   = i_cmd.dist_wr || i_cmd.dist_rd;
    assign w_d_addr = i_cmd.dist_wr ? {r_row, r_col} : {w_d_row, w_d_col};

    tsdc_ram #(
        .WIDTH (tsdc_pkg::DIST_W),
        .DEPTH (tsdc_pkg::MAX_CITIES * tsdc_pkg::MAX_CITIES)
    ) u_dist_ram (
        .i_clk   (i_clk),
        .i_en    (w_d_en),
        .i_we    (i_cmd.dist_wr),
        .i_addr  (w_d_addr),
        .i_wdata (r_dist),
        .o_rdata (w_d_q)
    );

    assign w_d_ext = $signed({{(tsdc_pkg::ACC_W - tsdc_pkg::DIST_W){1'b0}}, w_d_q});

    // The shared edge pair is added back only when the positions are neighbours.
    assign w_adj = (r_nb[0] == r_nb[4]) || (r_nb[2] == r_nb[4]) ||
                   (r_nb[3] == r_nb[1]) || (r_nb[5] == r_nb[1]);

    // Closing arithmetic.
    assign w_sum = $signed({2'b00, r_cost}) + $signed({r_acc[tsdc_pkg::ACC_W-1], r_acc});

    always_comb begin
        if (r_func == tsdc_pkg::FUNC_INIT) begin
            w_new_cost = r_acc[tsdc_pkg::COST_W-1:0];
        end else if (w_is_swap && w_swap_ok) begin
            if (w_sum < 0) begin
                w_new_cost = '0;
            end else if (w_sum > CMAX) begin
                w_new_cost = '1;
            end else begin
                w_new_cost = w_sum[tsdc_pkg::COST_W-1:0];
            end
        end else begin
            w_new_cost = r_cost;
        end
    end

    assign w_out_cost = w_new_cost[tsdc_pkg::COST_W-1] ? '1 :
                        w_new_cost[tsdc_pkg::OCOST_W-1:0];

    always_comb begin
        if (!(w_is_swap && w_swap_ok)) begin
            w_delta = '0;
        end else if (r_acc > DMAX) begin
            w_delta = DMAX[tsdc_pkg::DELTA_W-1:0];
        end else if (r_acc < DMIN) begin
            w_delta = DMIN[tsdc_pkg::DELTA_W-1:0];
        end else begin
            w_delta = r_acc[tsdc_pkg::DELTA_W-1:0];
        end
    end

    assign w_city  = ((r_func == tsdc_pkg::FUNC_READ) && w_pa_ok) ? r_nb[1] : '0;
    assign o_tdata = r_out;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_city_count <= tsdc_pkg::CC_RESET;
            r_cost       <= '0;
            r_tvalid     <= '0;
            r_tcap_en    <= 1'b0;
            r_acc_en     <= 1'b0;
            r_func       <= tsdc_pkg::FUNC_WRITE;
        end else begin
            if (i_cfg_we) begin
                r_city_count <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_func <= tsdc_pkg::t_func'(i_tuser);
            end
            if (i_cmd.tour_clear) begin
                r_tvalid <= '0;
            end else if (i_cmd.tour_wr) begin
                r_tvalid[w_t_addr] <= 1'b1;
            end
            r_tcap_en <= i_cmd.tour_rd;
            r_acc_en  <= i_cmd.dist_rd;
            if (i_cmd.finish) begin
                r_cost <= w_new_cost;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row  <= i_tdata[5:0];
            r_col  <= i_tdata[11:6];
            r_dist <= i_tdata[27:12];
            r_pa   <= i_tdata[33:28];
            r_pb   <= i_tdata[39:34];
        end
        if (i_cmd.tour_rd) begin
            r_tv_hit    <= r_tvalid[w_t_addr];
            r_taddr_q   <= w_t_addr;
            r_tcap_slot <= i_cmd.step[2:0];
        end
        if (r_tcap_en) begin
            r_nb[r_tcap_slot] <= w_t_rdata;
        end
        r_acc_neg  <= w_is_swap && (i_cmd.step < tsdc_pkg::STEP_W'(tsdc_pkg::NEG_SLOTS));
        r_acc_gate <= w_is_swap && (i_cmd.step >= tsdc_pkg::STEP_W'(tsdc_pkg::GATE_SLOT));
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_acc_en && !(r_acc_gate && !w_adj)) begin
            r_acc <= r_acc_neg ? tsdc_pkg::ACC_W'(r_acc - w_d_ext) :
                                 tsdc_pkg::ACC_W'(r_acc + w_d_ext);
        end
        if (i_cmd.finish) begin
            r_out <= {w_city, w_out_cost, w_delta};
        end
    end

endmodule

FILE: rtl/core/tour_swap_delta_cost.sv
// Tour swap cost engine: keeps a city-to-city distance table, a cyclic tour of
// city indices and the running cost of that closed tour.
// The input stream carries one operation per transaction: tuser selects write
// distance, init tour, swap positions or read position, and tdata carries the
// operands. Every accepted transaction gives exactly one result transaction on
// the output stream with the cost change, the running cost and a city index.
// The block works on one transaction at a time; a controller steps a datapath
// through single-port distance and tour RAMs, one access per cycle.
// A swap with an invalid or equal pair goes straight to its result; a valid swap
// makes six tour reads and ten distance reads, and init one distance read per
// tour edge of the active city count; the next transaction is taken once the
// controller is back in idle after the result is registered.
// The finished result sits in an output register, so a new transaction is
// accepted while the previous result still waits; a stalled receiver only
// holds the block once a second result is ready to be delivered.
// The city count register is written through the configuration port and must
// only change while the block is idle.
// Reset brings the tour to identity order, the cost to zero and the city
// count to 64; the distance table holds no defined contents until written.
module tour_swap_delta_cost (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tsdc_pkg::CC_W-1:0]           i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: row[5:0], col[11:6], distance[27:12], pos_a[33:28], pos_b[39:34]
    input  logic [tsdc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: func[1:0]
    input  logic [tsdc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: delta[19:0], tour_cost[41:20], city[47:42]
    output logic [tsdc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    tsdc_pkg::t_cmd    w_cmd;
    tsdc_pkg::t_status w_status;

    // The controller sequences each operation and owns both handshakes.
    tsdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the memories, the cost and the result register.
    tsdc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_tdata     (m_axis_tdata)
    );

endmodule

FILE: rtl/core/tsdc_chk.sv
`include "assert_macros.svh"

module tsdc_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [tsdc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // Transactions accepted whose result has not yet been delivered.
    logic [1:0] r_pending;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pending <= 2'(r_pending + 1'b1);
        end else if (!w_in_acc && w_out_acc) begin
            r_pending <= 2'(r_pending - 1'b1);
        end
    end

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    `ASSERT_CLK(a_no_orphan, i_clk, i_rst_n, m_axis_tvalid |-> r_pending != 2'd0)
    `ASSERT_CLK(a_one_waiting, i_clk, i_rst_n, s_axis_tready |-> r_pending <= 2'd1)
    `ASSERT_NEVER(a_no_overrun, i_clk, i_rst_n, r_pending == 2'd3)

endmodule

bind tour_swap_delta_cost tsdc_chk u_tsdc_chk (.*);
